### design/tpcrq_pkg.sv
// Package for the two-phase-commit ring queue: word types, operation codes,
// controller states and the command/status structs.
// No dependencies.
package tpcrq_pkg;

   localparam int QUEUE_ITEMS_DEF = 15;
   localparam int ITEM_W          = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH        = 2'd0,
      FUNC_PUSH_COMMIT = 2'd1,
      FUNC_POP         = 2'd2,
      FUNC_POP_COMMIT  = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [ITEM_W-1:0]   item_in;
   } req_word_type;

   typedef struct packed {
      logic                accepted;
      logic [ITEM_W-1:0]   item_out;
      logic                is_empty;
      logic                is_full;
   } rsp_word_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_READ = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic exec;        // carry out the operation of the word on the input
      logic finish_pop;  // load the read slot into the result register
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic out_valid;
   } status_type;

endpackage

### design/tpcrq_ctrl.sv
// Controller for the ring queue: input handshake and pop sequencing.
// Depends on tpcrq_pkg.
module tpcrq_ctrl
   import tpcrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  func_type   req_func,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         CTRL_IDLE: begin
            // take a word when the result register is free or drains now
            req_ready = !status.out_valid || rsp_ready;
            cmd.exec  = req_valid && req_ready;
            if (cmd.exec && req_func == FUNC_POP && !status.empty) begin
               state_in = CTRL_READ;
            end
         end
         CTRL_READ: begin
            cmd.finish_pop = 1'b1;
            state_in       = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

### design/tpcrq_datapath.sv
// Datapath for the ring queue: slot memory, committed and shadow pointers,
// result register. Depends on tpcrq_pkg.
module tpcrq_datapath
   import tpcrq_pkg::*;
#(
   parameter int QUEUE_ITEMS = QUEUE_ITEMS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  cmd_type      cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int RING  = QUEUE_ITEMS + 1;
   localparam int PTR_W = (RING > 1) ? $clog2(RING) : 1;

   logic [ITEM_W-1:0] slots [RING];
   logic [ITEM_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PTR_W-1:0] shadow_head_ff, shadow_head_in;
   logic [PTR_W-1:0] shadow_tail_ff, shadow_tail_in;
   logic             out_valid_ff, out_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             wr_en, rd_en, load_res, full, empty;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (ring_next(tail_ff) == head_ff);
   assign empty = (head_ff == tail_ff);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      shadow_head_in = shadow_head_ff;
      shadow_tail_in = shadow_tail_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      load_res       = 1'b0;
      rsp_word_in    = rsp_word_ff;
      if (cmd.exec) begin
         load_res             = 1'b1;
         rsp_word_in.accepted = 1'b1;
         rsp_word_in.item_out = '0;
         unique case (req_word.func)
            FUNC_PUSH: begin
               rsp_word_in.accepted = !full;
               if (!full) begin
                  wr_en          = 1'b1;
                  shadow_tail_in = ring_next(tail_ff);
               end
            end
            FUNC_PUSH_COMMIT: tail_in = shadow_tail_ff;
            FUNC_POP: begin
               // a hit waits for the registered slot read
               rsp_word_in.accepted = 1'b0;
               if (!empty) begin
                  rd_en          = 1'b1;
                  load_res       = 1'b0;
                  shadow_head_in = ring_next(head_ff);
               end
            end
            FUNC_POP_COMMIT: head_in = shadow_head_ff;
            default: ;
         endcase
         rsp_word_in.is_empty = (head_in == tail_in);
         rsp_word_in.is_full  = (ring_next(tail_in) == head_in);
      end else if (cmd.finish_pop) begin
         load_res             = 1'b1;
         rsp_word_in.accepted = 1'b1;
         rsp_word_in.item_out = rd_data_ff;
         rsp_word_in.is_empty = empty;
         rsp_word_in.is_full  = full;
      end
      out_valid_in = load_res || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[tail_ff] <= req_word.item_in;
      end
      if (rd_en) begin
         rd_data_ff <= slots[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         shadow_head_ff <= '0;
         shadow_tail_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         shadow_head_ff <= shadow_head_in;
         shadow_tail_ff <= shadow_tail_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign status.empty     = empty;
   assign status.out_valid = out_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_word         = rsp_word_ff;

endmodule

### design/two_phase_commit_ring_queue.sv
// Two-phase-commit ring queue of QUEUE_ITEMS item words (QUEUE_ITEMS+1 slots).
// Operations arrive on req_ (valid/ready) as req_word.func plus req_word.item_in:
// push, push commit, pop, pop commit. A push writes at the committed tail and
// stages the tail; a pop reads at the committed head and stages the head; each
// commit copies the staged pointer into the committed one.
// Every accepted word yields one result word on rsp_ (valid/ready): accepted,
// item_out (zero unless a pop hit), and the empty and full flags after the step.
// Push, both commits and a pop on an empty queue give their result in the
// cycle after acceptance; a pop that finds an item passes through the slot
// memory's registered read port first. Throughput: one word per cycle while the
// receiver keeps up, except that a hitting pop holds the input in CTRL_READ.
// The result register frees the input side: a new word is taken in the same
// cycle as the waiting result leaves. While the receiver stalls, the result
// holds and req_ready stays low.
// Reset clears the pointers and the result valid; slot contents are left as
// they are and are only defined once written.
module two_phase_commit_ring_queue
   import tpcrq_pkg::*;
#(
   parameter int QUEUE_ITEMS = QUEUE_ITEMS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   cmd_type    cmd;
   status_type status;

   tpcrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_word.func),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpcrq_datapath #(
      .QUEUE_ITEMS (QUEUE_ITEMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

### design/tpcrq_checker.sv
// Port-level checks for the ring queue, bound to the top level.
// Depends on tpcrq_pkg and two_phase_commit_ring_queue.
module tpcrq_checker
   import tpcrq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // result held while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.is_empty && rsp_word.is_full))
      else $error("queue reported empty and full at once");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.accepted |-> rsp_word.item_out == '0)
      else $error("refused word carries an item");

   // input is only taken while the result register is free or drains
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("word accepted over a waiting result");

endmodule

bind two_phase_commit_ring_queue tpcrq_checker u_tpcrq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
